### hw/rtl/tjap_pkg.sv
// Shared types, constants and helpers for the three-joint arm positioner.
package tjap_pkg;

    localparam int POSITION_BITS = 10;
    localparam int TOL_W         = 8;
    localparam int MAG_W         = 15;
    localparam int DRIVE_W       = 16;
    localparam int ERR3_W        = POSITION_BITS + 2;
    localparam int DEN_W         = POSITION_BITS + 2;
    localparam int NUM_W         = MAG_W + ERR3_W;
    localparam int DIV_STEPS     = 3;
    localparam int DIV_STAGES    = MAG_W / DIV_STEPS;
    // decide, multiply, divide stages, magnitude, output
    localparam int LATENCY       = DIV_STAGES + 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int PROD_W        = 2 * DRIVE_W;
    localparam int RECIP_SHIFT   = 19;

    // Q1.15 speed limits
    localparam logic [DRIVE_W-1:0] Q_0_10 = 16'd3277;
    localparam logic [DRIVE_W-1:0] Q_0_16 = 16'd5243;
    localparam logic [DRIVE_W-1:0] Q_0_30 = 16'd9830;
    localparam logic [DRIVE_W-1:0] Q_0_40 = 16'd13107;
    localparam logic [DRIVE_W-1:0] Q_0_56 = 16'd18350;
    localparam logic [DRIVE_W-1:0] Q_0_60 = 16'd19661;
    localparam logic [DRIVE_W-1:0] Q_0_80 = 16'd26214;
    localparam logic [DRIVE_W-1:0] Q_1_00 = 16'd32768;

    // 1/(0.03e+1) rewritten as 100/(3e+100)
    localparam logic [DEN_W-1:0]   DEN_BIAS  = DEN_W'(100);
    // ceil(x/10) = ((x + 9) * 52429) >> 19, exact for 16-bit x
    localparam logic [DRIVE_W-1:0] CEIL_BIAS = 16'd9;
    localparam logic [DRIVE_W-1:0] RECIP_10  = 16'd52429;

    localparam logic [POSITION_BITS-1:0] RST_SAFE_ELBOW = POSITION_BITS'(0);
    localparam logic [TOL_W-1:0]         RST_TOLERANCE  = TOL_W'(5);
    localparam logic [TOL_W-1:0]         RST_SAFE_BAND  = TOL_W'(20);
    localparam logic [POSITION_BITS-1:0] RST_HIGH_ZONE  = POSITION_BITS'(320);
    localparam logic [POSITION_BITS-1:0] RST_LOW_ZONE   = POSITION_BITS'(150);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SAFE_ELBOW = 3'd0,
        REG_TOLERANCE  = 3'd1,
        REG_SAFE_BAND  = 3'd2,
        REG_HIGH_ZONE  = 3'd3,
        REG_LOW_ZONE   = 3'd4
    } cfg_reg_t;

    typedef logic [POSITION_BITS-1:0] pos_t;

    typedef struct packed {
        pos_t current_shoulder;
        pos_t current_elbow;
        pos_t current_wrist;
        pos_t target_shoulder;
        pos_t target_elbow;
        pos_t target_wrist;
    } cmd_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] shoulder_drive;
        logic signed [DRIVE_W-1:0] elbow_drive;
        logic signed [DRIVE_W-1:0] wrist_drive;
        logic                      all_in_place;
    } result_t;

    typedef struct packed {
        pos_t             safe_elbow_position;
        logic [TOL_W-1:0] position_tolerance;
        logic [TOL_W-1:0] safe_band;
        pos_t             shoulder_high_zone;
        pos_t             shoulder_low_zone;
    } cfg_t;

    typedef struct packed {
        logic active;       // drive is nonzero
        logic neg;          // target above position
        logic scale;        // shoulder moving down, 0.9 scaling
        logic to_shoulder;  // arm lane result goes to the shoulder
        logic in_place;     // all three joints within tolerance
    } lane_ctl_t;

    typedef struct packed {
        pos_t             err;
        logic [MAG_W-1:0] lo;
        logic [MAG_W-1:0] span;
        lane_ctl_t        ctl;
    } lane_req_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] dsh;
        logic [MAG_W-1:0] quo;
        logic [MAG_W-1:0] lo;
        lane_ctl_t        ctl;
    } div_word_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        lane_ctl_t        ctl;
    } lane_out_t;

    function automatic pos_t abs_diff(input pos_t a, input pos_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### hw/rtl/tjap_decide.sv
// First stage: joint priority, zone selection and per-lane speed requests.
module tjap_decide
    import tjap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  cmd_t      cmd,
    input  cfg_t      cfg,
    output logic      out_valid,
    output lane_req_t arm_req,
    output lane_req_t wrist_req
);

    logic      valid_reg;
    lane_req_t arm_reg;
    lane_req_t arm_next;
    lane_req_t wrist_reg;
    lane_req_t wrist_next;

    always_comb
    begin
        pos_t               d_sh;
        pos_t               d_safe;
        pos_t               d_el;
        pos_t               d_wr;
        pos_t               tol;
        logic               sh_out;
        logic               el_out;
        logic               wr_out;
        logic [DRIVE_W-1:0] lo;
        logic [DRIVE_W-1:0] hi;
        logic [DRIVE_W-1:0] span;

        d_sh   = abs_diff(cmd.current_shoulder, cmd.target_shoulder);
        d_safe = abs_diff(cfg.safe_elbow_position, cmd.current_elbow);
        d_el   = abs_diff(cmd.current_elbow, cmd.target_elbow);
        d_wr   = abs_diff(cmd.current_wrist, cmd.target_wrist);
        tol    = POSITION_BITS'(cfg.position_tolerance);
        sh_out = d_sh > tol;
        el_out = d_el > tol;
        wr_out = d_wr > tol;

        arm_next = '0;
        lo       = Q_0_10;
        hi       = Q_0_80;
        priority if (sh_out && d_safe > POSITION_BITS'(cfg.safe_band))
        begin
            // park the elbow at its safe position first
            arm_next.err        = d_safe;
            arm_next.ctl.active = 1'b1;
            arm_next.ctl.neg    = cfg.safe_elbow_position > cmd.current_elbow;
            hi                  = Q_0_60;
        end
        else if (sh_out)
        begin
            arm_next.err             = d_sh;
            arm_next.ctl.active      = 1'b1;
            arm_next.ctl.to_shoulder = 1'b1;
            arm_next.ctl.neg         = cmd.target_shoulder > cmd.current_shoulder;
            arm_next.ctl.scale       = !(cmd.target_shoulder > cmd.current_shoulder);
            priority if (cmd.current_shoulder > cfg.shoulder_high_zone)
            begin
                lo = Q_0_16;
                hi = Q_0_60;
            end
            else if (cmd.current_shoulder < cfg.shoulder_low_zone)
            begin
                hi = Q_0_56;
            end
            else
            begin
                hi = Q_0_40;
            end
        end
        else if (el_out)
        begin
            arm_next.err        = d_el;
            arm_next.ctl.active = 1'b1;
            arm_next.ctl.neg    = cmd.target_elbow > cmd.current_elbow;
        end
        else
        begin
            arm_next.ctl.in_place = !wr_out;
        end
        span          = hi - lo;
        arm_next.lo   = lo[MAG_W-1:0];
        arm_next.span = span[MAG_W-1:0];

        wrist_next            = '0;
        wrist_next.err        = d_wr;
        wrist_next.ctl.active = wr_out;
        wrist_next.ctl.neg    = cmd.target_wrist > cmd.current_wrist;
        wrist_next.lo         = Q_0_30[MAG_W-1:0];
        span                  = Q_1_00 - Q_0_30;
        wrist_next.span       = span[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        arm_reg   <= arm_next;
        wrist_reg <= wrist_next;
    end

    assign out_valid = valid_reg;
    assign arm_req   = arm_reg;
    assign wrist_req = wrist_reg;

endmodule

### hw/rtl/tjap_div_stage.sv
// One pipeline stage of the restoring divider: three quotient bits per stage.
module tjap_div_stage
    import tjap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  div_word_t in_word,
    output logic      out_valid,
    output div_word_t out_word
);

    logic      valid_reg;
    div_word_t word_reg;
    div_word_t word_next;

    always_comb
    begin
        div_word_t w;
        w = in_word;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            if (w.rem >= w.dsh)
            begin
                w.rem = w.rem - w.dsh;
                w.quo = {w.quo[MAG_W-2:0], 1'b1};
            end
            else
            begin
                w.quo = {w.quo[MAG_W-2:0], 1'b0};
            end
            w.dsh = w.dsh >> 1;
        end
        word_next = w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### hw/rtl/tjap_speed_lane.sv
// Speed curve lane: lo + span*3e/(3e+100) through a multiply stage and a pipelined divider.
module tjap_speed_lane
    import tjap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  lane_req_t req,
    output logic      out_valid,
    output lane_out_t out
);

    logic             mul_valid_reg;
    div_word_t        mul_reg;
    div_word_t        mul_next;
    logic             stg_valid [DIV_STAGES+1];
    div_word_t        stg_word  [DIV_STAGES+1];
    logic             out_valid_reg;
    lane_out_t        out_reg;
    lane_out_t        out_next;

    always_comb
    begin
        logic [ERR3_W-1:0] err3;
        logic [DEN_W-1:0]  den;
        err3         = ERR3_W'(req.err) + (ERR3_W'(req.err) << 1);
        den          = DEN_W'(err3) + DEN_BIAS;
        mul_next.rem = NUM_W'(req.span) * NUM_W'(err3);
        // quotient is below 2^MAG_W, so start with the divisor at the top bit
        mul_next.dsh = NUM_W'(den) << (MAG_W - 1);
        mul_next.quo = '0;
        mul_next.lo  = req.lo;
        mul_next.ctl = req.ctl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            out_valid_reg <= stg_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
        out_reg <= out_next;
    end

    assign stg_valid[0] = mul_valid_reg;
    assign stg_word[0]  = mul_reg;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        tjap_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_word   (stg_word[k]),
            .out_valid (stg_valid[k+1]),
            .out_word  (stg_word[k+1])
        );
    end

    always_comb
    begin
        out_next.mag = stg_word[DIV_STAGES].lo + stg_word[DIV_STAGES].quo;
        out_next.ctl = stg_word[DIV_STAGES].ctl;
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

### hw/rtl/tjap_finish.sv
// Output stage: 0.9 reverse scaling, drive sign, joint routing and result register.
module tjap_finish
    import tjap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  lane_out_t arm,
    input  lane_out_t wrist,
    output logic      done,
    output result_t   result
);

    logic    done_reg;
    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        logic [DRIVE_W-1:0]        biased;
        logic [PROD_W-1:0]         prod;
        logic [MAG_W-1:0]          tenth;
        logic [MAG_W-1:0]          scaled;
        logic signed [DRIVE_W-1:0] arm_drive;

        // m*9/10 truncated equals m - ceil(m/10)
        biased = DRIVE_W'(arm.mag) + CEIL_BIAS;
        prod   = PROD_W'(biased) * PROD_W'(RECIP_10);
        tenth  = MAG_W'(prod >> RECIP_SHIFT);
        scaled = arm.mag - tenth;

        priority if (!arm.ctl.active)
        begin
            arm_drive = '0;
        end
        else if (arm.ctl.scale)
        begin
            arm_drive = $signed({1'b0, scaled});
        end
        else if (arm.ctl.neg)
        begin
            arm_drive = -$signed({1'b0, arm.mag});
        end
        else
        begin
            arm_drive = $signed({1'b0, arm.mag});
        end

        result_next.shoulder_drive = arm.ctl.to_shoulder ? arm_drive : '0;
        result_next.elbow_drive    = arm.ctl.to_shoulder ? '0 : arm_drive;

        priority if (!wrist.ctl.active)
        begin
            result_next.wrist_drive = '0;
        end
        else if (wrist.ctl.neg)
        begin
            result_next.wrist_drive = -$signed({1'b0, wrist.mag});
        end
        else
        begin
            result_next.wrist_drive = $signed({1'b0, wrist.mag});
        end

        result_next.all_in_place = arm.ctl.in_place;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hw/rtl/three_joint_arm_positioner.sv
// Three-joint arm positioner: configuration registers and the drive pipeline.
//
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. busy is never raised, so a new position set may be issued every
// cycle; one result comes back for each command, in order.
// Result channel: done is high for exactly one cycle with the drives and the
// all_in_place flag on result; the receiver has no way to stall and must take it.
// Pipeline: done follows the accepting edge through decide, multiply, five divider
// stages, magnitude and output register. Throughput is one command per cycle, set by
// the divider: each of its five stages retires three quotient bits.
// Configuration: cfg_ready is always high; a transaction with cfg_valid writes
// register cfg_index (safe elbow, tolerance, safe band, high zone, low zone).
// Unknown indexes are dropped. Write only while no command is in flight.
// Reset: rst_n is asynchronous, active low; it empties the pipeline (no done)
// and restores the register defaults 0, 5, 20, 320, 150.
module three_joint_arm_positioner
    import tjap_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  cmd_t                     cmd,
    output logic                     done,
    output result_t                  result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [POSITION_BITS-1:0] cfg_data
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      dec_valid;
    lane_req_t arm_req;
    lane_req_t wrist_req;
    logic      arm_valid;
    logic      wrist_valid;
    lane_out_t arm_out;
    lane_out_t wrist_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SAFE_ELBOW: cfg_next.safe_elbow_position = cfg_data;
                REG_TOLERANCE:  cfg_next.position_tolerance  = cfg_data[TOL_W-1:0];
                REG_SAFE_BAND:  cfg_next.safe_band           = cfg_data[TOL_W-1:0];
                REG_HIGH_ZONE:  cfg_next.shoulder_high_zone  = cfg_data;
                REG_LOW_ZONE:   cfg_next.shoulder_low_zone   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.safe_elbow_position <= RST_SAFE_ELBOW;
            cfg_reg.position_tolerance  <= RST_TOLERANCE;
            cfg_reg.safe_band           <= RST_SAFE_BAND;
            cfg_reg.shoulder_high_zone  <= RST_HIGH_ZONE;
            cfg_reg.shoulder_low_zone   <= RST_LOW_ZONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tjap_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .out_valid (dec_valid),
        .arm_req   (arm_req),
        .wrist_req (wrist_req)
    );

    tjap_speed_lane u_arm_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .req       (arm_req),
        .out_valid (arm_valid),
        .out       (arm_out)
    );

    tjap_speed_lane u_wrist_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .req       (wrist_req),
        .out_valid (wrist_valid),
        .out       (wrist_out)
    );

    tjap_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (arm_valid && wrist_valid),
        .arm      (arm_out),
        .wrist    (wrist_out),
        .done     (done),
        .result   (result)
    );

endmodule

### hw/rtl/tjap_checker.sv
// Port-level checks for the arm positioner, bound to the top level.
module tjap_checker
    import tjap_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    localparam logic signed [DRIVE_W-1:0] WRIST_MIN = Q_0_30;

    logic [LATENCY-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= {acc_reg[LATENCY-2:0], start && !busy};
        end
    end

    // one result per command, matched against a shift register of accepted commands
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == acc_reg[LATENCY-1])
        else $error("result strobe does not match command transaction");

    a_in_place_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.all_in_place |->
            result.shoulder_drive == 0 && result.elbow_drive == 0
            && result.wrist_drive == 0)
        else $error("drive nonzero while all joints in place");

    a_one_arm_joint: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.shoulder_drive == 0 || result.elbow_drive == 0)
        else $error("shoulder and elbow driven together");

    a_wrist_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.wrist_drive != 0 |->
            result.wrist_drive >= WRIST_MIN || result.wrist_drive <= -WRIST_MIN)
        else $error("wrist drive below minimum speed");

endmodule

bind three_joint_arm_positioner tjap_checker u_checker (.*);

### tb/three_joint_arm_positioner_tb.sv
// Testbench for the three-joint arm positioner: directed and random commands, self-checking.
`timescale 1ns / 1ps

module three_joint_arm_positioner_tb;
    import tjap_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 125;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    cmd_t                     cmd;
    logic                     done;
    result_t                  result;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [POSITION_BITS-1:0] cfg_data;

    cfg_t    arm_cfg;
    result_t expected_drives[$];
    int      mismatches;
    int      burst_left;
    bit      gaps_on;
    int      idle_cycles;

    three_joint_arm_positioner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pos_gap(int a, int b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // lo + (hi - lo) * 3e / (3e + 100), truncated
    function automatic int speed_mag(int lo, int hi, int err);
        longint num;
        longint den;
        num = longint'(hi - lo) * err * 3;
        den = longint'(err) * 3 + 100;
        return lo + int'(num / den);
    endfunction

    function automatic result_t predict_drives(cmd_t c, cfg_t k);
        result_t r;
        int      sd;
        int      ed;
        int      wd;
        int      m;
        int      lo;
        int      hi;
        int      tol;
        bit      arm_ok;
        bit      wrist_ok;
        sd       = 0;
        ed       = 0;
        wd       = 0;
        arm_ok   = 1'b0;
        wrist_ok = 1'b0;
        tol      = int'(k.position_tolerance);
        if (pos_gap(c.current_shoulder, c.target_shoulder) > tol)
        begin
            if (pos_gap(k.safe_elbow_position, c.current_elbow) > int'(k.safe_band))
            begin
                // park the elbow first, shoulder held
                m  = speed_mag(Q_0_10, Q_0_60,
                               pos_gap(c.current_elbow, k.safe_elbow_position));
                ed = (k.safe_elbow_position > c.current_elbow) ? -m : m;
            end
            else
            begin
                if (c.current_shoulder > k.shoulder_high_zone)
                begin
                    lo = Q_0_16;
                    hi = Q_0_60;
                end
                else if (c.current_shoulder < k.shoulder_low_zone)
                begin
                    lo = Q_0_10;
                    hi = Q_0_56;
                end
                else
                begin
                    lo = Q_0_10;
                    hi = Q_0_40;
                end
                m  = speed_mag(lo, hi, pos_gap(c.current_shoulder, c.target_shoulder));
                sd = (c.target_shoulder > c.current_shoulder) ? -m : (m * 9) / 10;
            end
        end
        else if (pos_gap(c.current_elbow, c.target_elbow) > tol)
        begin
            m  = speed_mag(Q_0_10, Q_0_80, pos_gap(c.current_elbow, c.target_elbow));
            ed = (c.target_elbow > c.current_elbow) ? -m : m;
        end
        else
        begin
            arm_ok = 1'b1;
        end
        if (pos_gap(c.current_wrist, c.target_wrist) > tol)
        begin
            m  = speed_mag(Q_0_30, Q_1_00, pos_gap(c.current_wrist, c.target_wrist));
            wd = (c.target_wrist > c.current_wrist) ? -m : m;
        end
        else
        begin
            wrist_ok = 1'b1;
        end
        r.shoulder_drive = DRIVE_W'(sd);
        r.elbow_drive    = DRIVE_W'(ed);
        r.wrist_drive    = DRIVE_W'(wd);
        r.all_in_place   = arm_ok && wrist_ok;
        return r;
    endfunction

    // Scoreboard: predict on accept, mirror register writes, check on done.
    always @(posedge clk)
    begin : check_drives
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_drives.size() == 0)
                begin
                    $error("result with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_drives.pop_front();
                    if (result.shoulder_drive !== want.shoulder_drive)
                    begin
                        $error("shoulder_drive: expected %0d, got %0d",
                               want.shoulder_drive, result.shoulder_drive);
                        mismatches++;
                    end
                    if (result.elbow_drive !== want.elbow_drive)
                    begin
                        $error("elbow_drive: expected %0d, got %0d",
                               want.elbow_drive, result.elbow_drive);
                        mismatches++;
                    end
                    if (result.wrist_drive !== want.wrist_drive)
                    begin
                        $error("wrist_drive: expected %0d, got %0d",
                               want.wrist_drive, result.wrist_drive);
                        mismatches++;
                    end
                    if (result.all_in_place !== want.all_in_place)
                    begin
                        $error("all_in_place: expected %0b, got %0b",
                               want.all_in_place, result.all_in_place);
                        mismatches++;
                    end
                end
            end
            // a command sees the registers as they stood before this edge
            if (start && !busy)
                expected_drives.push_back(predict_drives(cmd, arm_cfg));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SAFE_ELBOW: arm_cfg.safe_elbow_position = cfg_data;
                    REG_TOLERANCE:  arm_cfg.position_tolerance  = cfg_data[TOL_W-1:0];
                    REG_SAFE_BAND:  arm_cfg.safe_band           = cfg_data[TOL_W-1:0];
                    REG_HIGH_ZONE:  arm_cfg.shoulder_high_zone  = cfg_data;
                    REG_LOW_ZONE:   arm_cfg.shoulder_low_zone   = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: ends the run after too long with no transaction on any channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic cmd_t make_cmd(int cs, int ce, int cw, int ts, int te, int tw);
        cmd_t c;
        c.current_shoulder = pos_t'(cs);
        c.current_elbow    = pos_t'(ce);
        c.current_wrist    = pos_t'(cw);
        c.target_shoulder  = pos_t'(ts);
        c.target_elbow     = pos_t'(te);
        c.target_wrist     = pos_t'(tw);
        return c;
    endfunction

    function automatic pos_t near_pos(int base, int span);
        int v;
        v = base + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > (1 << POSITION_BITS) - 1)
            v = (1 << POSITION_BITS) - 1;
        return pos_t'(v);
    endfunction

    // Weighted toward the interesting regions: joints near target, elbow near park.
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   tol;
        int   pick;
        tol = int'(arm_cfg.position_tolerance);
        c   = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            c.current_shoulder = near_pos(c.target_shoulder, tol);
        else if (pick < 5)
            c.current_shoulder = near_pos(c.target_shoulder, tol + 40);
        if ($urandom_range(0, 1))
            c.current_elbow = near_pos(arm_cfg.safe_elbow_position,
                                       int'(arm_cfg.safe_band) + 3);
        if ($urandom_range(0, 1))
            c.target_elbow = near_pos(c.current_elbow, tol + 30);
        pick = $urandom_range(0, 2);
        if (pick == 0)
            c.current_wrist = near_pos(c.target_wrist, tol);
        else if (pick == 1)
            c.current_wrist = near_pos(c.target_wrist, tol + 60);
        return c;
    endfunction

    task automatic idle_gap(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_cmd(cmd_t c);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                idle_gap($urandom_range(1, 8));
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [POSITION_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Unused upper data bits on the 8-bit registers are randomized; the block drops them.
    task automatic load_config(cfg_t k);
        wait_idle();
        write_reg(REG_SAFE_ELBOW, k.safe_elbow_position);
        write_reg(REG_TOLERANCE, {(POSITION_BITS - TOL_W)'($urandom), k.position_tolerance});
        write_reg(REG_SAFE_BAND, {(POSITION_BITS - TOL_W)'($urandom), k.safe_band});
        write_reg(REG_HIGH_ZONE, k.shoulder_high_zone);
        write_reg(REG_LOW_ZONE, k.shoulder_low_zone);
    endtask

    task automatic test_default_config();
        // reset config: safe 0, tol 5, band 20, zones 320 / 150
        send_cmd(make_cmd(0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(1023, 1023, 1023, 1023, 1023, 1023));
        send_cmd(make_cmd(0, 0, 1023, 1023, 0, 0));          // low zone up, wrist full down
        send_cmd(make_cmd(1023, 20, 0, 0, 20, 1023));        // high zone down, band edge
        send_cmd(make_cmd(500, 21, 7, 400, 21, 7));          // elbow just outside band
        send_cmd(make_cmd(320, 5, 9, 330, 5, 9));            // at high threshold: mid zone
        send_cmd(make_cmd(321, 0, 9, 300, 0, 9));
        send_cmd(make_cmd(150, 10, 9, 100, 10, 9));          // at low threshold: mid zone
        send_cmd(make_cmd(149, 10, 9, 200, 10, 9));
        send_cmd(make_cmd(200, 100, 300, 205, 1023, 305));   // shoulder at tolerance edge
        send_cmd(make_cmd(200, 1023, 300, 206, 0, 294));     // elbow parks from the top
        send_cmd(make_cmd(600, 1023, 300, 600, 0, 306));
        send_cmd(make_cmd(600, 500, 300, 605, 495, 295));    // in place with nonzero errors
    endtask

    task automatic test_config_extremes();
        cfg_t k;
        // zero tolerance and band, parked elbow at the top, overlapping zones
        k = '{safe_elbow_position: 1023, position_tolerance: 0, safe_band: 0,
              shoulder_high_zone: 0, shoulder_low_zone: 1023};
        load_config(k);
        send_cmd(make_cmd(500, 1023, 3, 501, 1023, 3));      // overlap: high zone wins
        send_cmd(make_cmd(0, 1023, 3, 1, 1023, 3));
        send_cmd(make_cmd(10, 1022, 40, 10, 1023, 40));
        send_cmd(make_cmd(0, 0, 40, 1023, 0, 40));
        send_cmd(make_cmd(77, 88, 99, 77, 88, 99));
        k = '{safe_elbow_position: 0, position_tolerance: 255, safe_band: 255,
              shoulder_high_zone: 1023, shoulder_low_zone: 0};
        load_config(k);
        send_cmd(make_cmd(1023, 255, 0, 767, 255, 0));       // neither zone test fires
        send_cmd(make_cmd(0, 0, 0, 255, 256, 255));
        send_cmd(make_cmd(255, 255, 255, 0, 0, 0));
        // writes to unmapped indexes must leave the registers alone
        wait_idle();
        for (int i = REG_LOW_ZONE + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), POSITION_BITS'($urandom));
        send_cmd(make_cmd(1023, 256, 0, 767, 256, 0));
    endtask

    task automatic test_random_sweep();
        cfg_t k;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: k = '0;
                1: k = '{safe_elbow_position: 1023, position_tolerance: 255, safe_band: 255,
                         shoulder_high_zone: 1023, shoulder_low_zone: 1023};
                2: k = '{safe_elbow_position: RST_SAFE_ELBOW, position_tolerance: RST_TOLERANCE,
                         safe_band: RST_SAFE_BAND, shoulder_high_zone: RST_HIGH_ZONE,
                         shoulder_low_zone: RST_LOW_ZONE};
                default:
                begin
                    k.safe_elbow_position = pos_t'($urandom);
                    k.position_tolerance  = ($urandom_range(0, 3) == 0) ?
                                            TOL_W'($urandom) : TOL_W'($urandom_range(0, 12));
                    k.safe_band           = ($urandom_range(0, 3) == 0) ?
                                            TOL_W'($urandom) : TOL_W'($urandom_range(0, 40));
                    k.shoulder_high_zone  = pos_t'($urandom);
                    k.shoulder_low_zone   = pos_t'($urandom);
                end
            endcase
            load_config(k);
            gaps_on = (phase % 3 != 1);
            repeat (PHASE_ITEMS) send_cmd(random_cmd());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        burst_left = 0;
        gaps_on    = 1'b1;
        arm_cfg    = '{safe_elbow_position: RST_SAFE_ELBOW, position_tolerance: RST_TOLERANCE,
                       safe_band: RST_SAFE_BAND, shoulder_high_zone: RST_HIGH_ZONE,
                       shoulder_low_zone: RST_LOW_ZONE};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_default_config();
        test_config_extremes();
        test_random_sweep();

        wait_idle();
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
